[rtl/lqr_ib_pkg.sv]
// Package for the LQR balance step block: widths, register indexes, the
// configuration and multiplier request structs, and the saturation helper.
// No dependencies.
package lqr_ib_pkg;

    localparam int DATA_W  = 32;
    localparam int GAIN_W  = 16;
    localparam int TICK_W  = 16;
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 33;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 52;
    localparam int SAT_W   = 66;
    localparam int APB_AW  = 6;
    localparam int APB_DW  = 64;

    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    typedef enum logic [2:0] {
        REG_PERIOD  = 3'd0,
        REG_TIMEOUT = 3'd1,
        REG_FWD_SC  = 3'd2,
        REG_YAW_SC  = 3'd3,
        REG_GAIN_A  = 3'd4,
        REG_GAIN_B  = 3'd5,
        REG_GAIN_C  = 3'd6,
        REG_TRIM    = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [TICK_W-1:0]        period;
        logic [TICK_W-1:0]        timeout;
        logic signed [DATA_W-1:0] fwd_scale;
        logic signed [DATA_W-1:0] yaw_scale;
        logic [APB_DW-1:0]        gain_a;
        logic [APB_DW-1:0]        gain_b;
        logic [APB_DW-1:0]        gain_c;
        logic signed [DATA_W-1:0] trim;
    } cfg_t;

    typedef struct packed {
        logic                      issue;
        logic                      acc_en;
        logic                      first;
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } mac_req_t;

    localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(64'sh0000_0000_7FFF_FFFF);
    localparam logic signed [SAT_W-1:0] SAT_LO = SAT_W'(-64'sh0000_0000_8000_0000);

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[DATA_W-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[DATA_W-1:0];
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

[rtl/lqr_ib_regs.sv]
// Configuration register file of the LQR balance step block, APB write/read.
// Depends on lqr_ib_pkg.
module lqr_ib_regs
    import lqr_ib_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[5:3]);
    assign wr_en  = psel & penable & pwrite & pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.period    <= TICK_W'(10);
            cfg_reg.timeout   <= TICK_W'(500);
            cfg_reg.fwd_scale <= '0;
            cfg_reg.yaw_scale <= '0;
            cfg_reg.gain_a    <= '0;
            cfg_reg.gain_b    <= '0;
            cfg_reg.gain_c    <= '0;
            cfg_reg.trim      <= DATA_W'(4915);
        end else if (wr_en) begin
            unique case (idx)
                REG_PERIOD:  cfg_reg.period    <= pwdata[TICK_W-1:0];
                REG_TIMEOUT: cfg_reg.timeout   <= pwdata[TICK_W-1:0];
                REG_FWD_SC:  cfg_reg.fwd_scale <= pwdata[DATA_W-1:0];
                REG_YAW_SC:  cfg_reg.yaw_scale <= pwdata[DATA_W-1:0];
                REG_GAIN_A:  cfg_reg.gain_a    <= pwdata;
                REG_GAIN_B:  cfg_reg.gain_b    <= pwdata;
                REG_GAIN_C:  cfg_reg.gain_c    <= pwdata;
                REG_TRIM:    cfg_reg.trim      <= pwdata[DATA_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_PERIOD:  prdata = APB_DW'(cfg_reg.period);
            REG_TIMEOUT: prdata = APB_DW'(cfg_reg.timeout);
            REG_FWD_SC:  prdata = APB_DW'(unsigned'(cfg_reg.fwd_scale));
            REG_YAW_SC:  prdata = APB_DW'(unsigned'(cfg_reg.yaw_scale));
            REG_GAIN_A:  prdata = cfg_reg.gain_a;
            REG_GAIN_B:  prdata = cfg_reg.gain_b;
            REG_GAIN_C:  prdata = cfg_reg.gain_c;
            REG_TRIM:    prdata = APB_DW'(unsigned'(cfg_reg.trim));
        endcase
    end

endmodule

[rtl/lqr_ib_mac.sv]
// Shared multiply-accumulate unit: registered product, then registered
// accumulator. Depends on lqr_ib_pkg.
module lqr_ib_mac
    import lqr_ib_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  mac_req_t                 req,
    output logic signed [PROD_W-1:0] prod,
    output logic signed [ACC_W-1:0]  acc
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     acc_vld_reg;
    logic                     acc_first_reg;

    // Product stage carries no reset: only the control flags below do.
    always_ff @(posedge aclk) begin
        if (req.issue) begin
            prod_reg <= PROD_W'(req.a) * PROD_W'(req.b);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_vld_reg   <= 1'b0;
            acc_first_reg <= 1'b0;
        end else begin
            acc_vld_reg   <= req.issue & req.acc_en;
            acc_first_reg <= req.first;
        end
    end

    // Gain products fit in ACC_W bits; drop the unused top of the product.
    always_ff @(posedge aclk) begin
        if (acc_vld_reg) begin
            if (acc_first_reg) begin
                acc_reg <= prod_reg[ACC_W-1:0];
            end else begin
                acc_reg <= acc_reg + prod_reg[ACC_W-1:0];
            end
        end
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule

[rtl/lqr_integral_balance_step.sv]
// Top level of the LQR balance step block: tick bookkeeping, control-step
// sequencer and result register. Depends on lqr_ib_pkg, lqr_ib_regs, lqr_ib_mac.
//
// One request on the s_ side is one base tick. A tick updates the command
// age, latches a new velocity command when s_tuser is set, and counts
// ticks toward the control period. A tick that does not reach the period
// gives no result and is taken without a stall, so the next request may
// follow at once. A tick that reaches the period starts a control step: the
// block drops s_tready while a small sequencer drives one shared 32x33
// multiplier (product and accumulator registered) through 14 products, two
// for wheel odometry and twelve for the 2x6 gain matrix. The result then
// goes to the m_ side output register; if an earlier result still waits
// there, the sequencer holds until it is taken. The output register lets
// new non-step ticks be taken while a result waits. All values are Q16.16,
// the gains Q8.8; every integrator and result saturates to 32 bits, and
// right shifts round toward minus infinity. Reset clears the integrators,
// references and counters; configuration returns to its reset values
// (period 10, timeout 500, trim 0.075, scales and gains zero). Registers
// sit at byte address 8*i on the 64-bit APB port and must be written only
// while the block is idle.
module lqr_integral_balance_step
    import lqr_ib_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // s_tdata, lowest bit up: left_wheel_speed, right_wheel_speed, body_pitch,
    // body_pitch_rate, body_yaw_rate, cmd_fwd_speed, cmd_yaw_rate
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [223:0]      s_tdata,
    // s_tuser: cmd_present
    input  logic              s_tuser,
    // m_tdata, lowest bit up: left_effort, right_effort, odo_fwd_speed,
    // odo_yaw_rate
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [127:0]      m_tdata,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    typedef enum logic {S_IDLE, S_RUN} state_t;

    cfg_t                     cfg;
    mac_req_t                 mac_req;
    logic signed [PROD_W-1:0] mac_prod;
    logic signed [ACC_W-1:0]  mac_acc;

    lqr_ib_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lqr_ib_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mac_req),
        .prod    (mac_prod),
        .acc     (mac_acc)
    );

    // Input fields.
    logic signed [DATA_W-1:0] in_left, in_right, in_pitch, in_pitch_rate;
    logic signed [DATA_W-1:0] in_yaw_rate, in_cmd_fwd, in_cmd_yaw;

    assign in_left       = s_tdata[31:0];
    assign in_right      = s_tdata[63:32];
    assign in_pitch      = s_tdata[95:64];
    assign in_pitch_rate = s_tdata[127:96];
    assign in_yaw_rate   = s_tdata[159:128];
    assign in_cmd_fwd    = s_tdata[191:160];
    assign in_cmd_yaw    = s_tdata[223:192];

    state_t                   state_reg;
    logic [3:0]               idx_reg;
    logic [TICK_W-1:0]        ticks_reg, age_reg;
    logic signed [DATA_W-1:0] ref_fwd_reg, ref_yaw_reg;
    logic signed [DATA_W-1:0] fwd_int_reg, yaw_int_reg;
    logic signed [DATA_W-1:0] step_ref_fwd_reg;
    logic signed [MUL_B_W-1:0] sum_lr_reg, dif_rl_reg;
    logic signed [DATA_W-1:0] pitch_rate_reg, yaw_rate_reg, pitch_st_reg;
    logic signed [DATA_W-1:0] odo_fwd_reg, odo_yaw_reg, eff0_reg;
    logic                     m_valid_reg;
    logic [127:0]             m_data_reg;

    logic                     accept;
    logic                     out_free;
    logic                     out_load;
    logic [TICK_W-1:0]        age_next, ticks_inc;
    logic signed [DATA_W-1:0] ref_fwd_next, ref_yaw_next;
    logic                     step_now, stale;
    logic signed [DATA_W-1:0] yaw_int_next, fwd_int_next, pitch_st_next;
    logic signed [DATA_W-1:0] odo_next, eff_next;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid & s_tready;
    assign out_free = ~m_valid_reg | m_tready;
    assign out_load = (state_reg == S_RUN) && (idx_reg == 4'd15) && out_free;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Tick bookkeeping: age, command latch, period count, staleness.
    always_comb begin
        age_next     = (age_reg != TICK_MAX) ? age_reg + TICK_W'(1) : age_reg;
        ref_fwd_next = ref_fwd_reg;
        ref_yaw_next = ref_yaw_reg;
        if (s_tuser) begin
            age_next     = '0;
            ref_fwd_next = in_cmd_fwd;
            ref_yaw_next = in_cmd_yaw;
        end
        ticks_inc = (ticks_reg != TICK_MAX) ? ticks_reg + TICK_W'(1) : ticks_reg;
        step_now  = (ticks_inc >= cfg.period);
        stale     = (age_next > cfg.timeout);
        yaw_int_next  = sat32(SAT_W'(yaw_int_reg) + SAT_W'(ref_yaw_next)
                              - SAT_W'(in_yaw_rate));
        pitch_st_next = sat32(SAT_W'(in_pitch) - SAT_W'(cfg.trim));
    end

    // Odometry from the raw product; effort from the negated row sum.
    assign odo_next     = sat32(SAT_W'(mac_prod >>> 16));
    assign eff_next     = sat32(-SAT_W'(mac_acc >>> 8));
    assign fwd_int_next = sat32(SAT_W'(fwd_int_reg) + SAT_W'(step_ref_fwd_reg)
                                - SAT_W'(odo_fwd_reg));

    // Gain picker: row r, column c of the packed Q8.8 words.
    function automatic logic signed [MUL_A_W-1:0] gain(input cfg_t c, input int k);
        logic [APB_DW-1:0]        w;
        logic signed [GAIN_W-1:0] g;
        w = (k < 4) ? c.gain_a : (k < 8) ? c.gain_b : c.gain_c;
        g = w[16*(k%4) +: GAIN_W];
        return MUL_A_W'(g);
    endfunction

    // Sequencer schedule: odometry first, then row 0 and row 1. The odometry
    // and integral columns go last in each row so their values are ready.
    always_comb begin
        mac_req.issue  = (state_reg == S_RUN) && (idx_reg <= 4'd13);
        mac_req.acc_en = (idx_reg >= 4'd2);
        mac_req.first  = (idx_reg == 4'd2) || (idx_reg == 4'd8);
        mac_req.a      = '0;
        mac_req.b      = '0;
        unique case (idx_reg)
            4'd0:  begin mac_req.a = cfg.fwd_scale; mac_req.b = sum_lr_reg; end
            4'd1:  begin mac_req.a = cfg.yaw_scale; mac_req.b = dif_rl_reg; end
            4'd2:  begin mac_req.a = gain(cfg, 1);  mac_req.b = MUL_B_W'(pitch_rate_reg); end
            4'd3:  begin mac_req.a = gain(cfg, 2);  mac_req.b = MUL_B_W'(yaw_rate_reg); end
            4'd4:  begin mac_req.a = gain(cfg, 3);  mac_req.b = MUL_B_W'(pitch_st_reg); end
            4'd5:  begin mac_req.a = gain(cfg, 0);  mac_req.b = MUL_B_W'(odo_fwd_reg); end
            4'd6:  begin mac_req.a = gain(cfg, 4);  mac_req.b = MUL_B_W'(fwd_int_reg); end
            4'd7:  begin mac_req.a = gain(cfg, 5);  mac_req.b = MUL_B_W'(yaw_int_reg); end
            4'd8:  begin mac_req.a = gain(cfg, 7);  mac_req.b = MUL_B_W'(pitch_rate_reg); end
            4'd9:  begin mac_req.a = gain(cfg, 8);  mac_req.b = MUL_B_W'(yaw_rate_reg); end
            4'd10: begin mac_req.a = gain(cfg, 9);  mac_req.b = MUL_B_W'(pitch_st_reg); end
            4'd11: begin mac_req.a = gain(cfg, 6);  mac_req.b = MUL_B_W'(odo_fwd_reg); end
            4'd12: begin mac_req.a = gain(cfg, 10); mac_req.b = MUL_B_W'(fwd_int_reg); end
            4'd13: begin mac_req.a = gain(cfg, 11); mac_req.b = MUL_B_W'(yaw_int_reg); end
            default: begin mac_req.a = '0; mac_req.b = '0; end
        endcase
    end

    // Payload captured at every accepted request; no reset needed.
    always_ff @(posedge aclk) begin
        if (accept) begin
            sum_lr_reg       <= MUL_B_W'(in_left) + MUL_B_W'(in_right);
            dif_rl_reg       <= MUL_B_W'(in_right) - MUL_B_W'(in_left);
            pitch_rate_reg   <= in_pitch_rate;
            yaw_rate_reg     <= in_yaw_rate;
            pitch_st_reg     <= pitch_st_next;
            step_ref_fwd_reg <= ref_fwd_next;
        end
        if (state_reg == S_RUN) begin
            if (idx_reg == 4'd1) odo_fwd_reg <= odo_next;
            if (idx_reg == 4'd2) odo_yaw_reg <= odo_next;
            if (idx_reg == 4'd9) eff0_reg    <= eff_next;
        end
    end

    // State machine, tick state and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            idx_reg     <= '0;
            ticks_reg   <= '0;
            age_reg     <= '0;
            ref_fwd_reg <= '0;
            ref_yaw_reg <= '0;
            fwd_int_reg <= '0;
            yaw_int_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // Load a finished result, else drop the one just taken.
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        age_reg   <= age_next;
                        ticks_reg <= step_now ? '0 : ticks_inc;
                        // A step sees the fresh command; staleness applies after it.
                        ref_fwd_reg <= stale ? '0 : ref_fwd_next;
                        ref_yaw_reg <= stale ? '0 : ref_yaw_next;
                        if (step_now) begin
                            yaw_int_reg <= yaw_int_next;
                            idx_reg     <= '0;
                            state_reg   <= S_RUN;
                        end
                    end
                end
                S_RUN: begin
                    if (idx_reg == 4'd2) fwd_int_reg <= fwd_int_next;
                    if (idx_reg != 4'd15) begin
                        idx_reg <= idx_reg + 4'd1;
                    end else if (out_free) begin
                        // Hold here until the output register is free.
                        m_data_reg  <= {odo_yaw_reg, odo_fwd_reg, eff_next, eff0_reg};
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
